FILE: rtl/bal_pkg.sv
package bal_pkg;

   localparam int Capacity = 128;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);

   localparam logic [2:0] OP_APPEND     = 3'd0;
   localparam logic [2:0] OP_DELETE_KEY = 3'd1;
   localparam logic [2:0] OP_FIND_KEY   = 3'd2;
   localparam logic [2:0] OP_INSERT_AT  = 3'd3;
   localparam logic [2:0] OP_REMOVE_AT  = 3'd4;
   localparam logic [2:0] OP_READ_AT    = 3'd5;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      logic              shift_up;
      logic              walk;
      logic              tail_we;
      logic [IdxW-1:0]   ins_pos;
      logic [IdxW-1:0]   rem_pos;
      entry_type         new_entry;
   } cell_ctl_type;

endpackage

FILE: rtl/bal_cell.sv
module bal_cell (
   input  logic                      clock,
   input  logic [bal_pkg::IdxW-1:0]  index,
   input  bal_pkg::cell_ctl_type     ctl,
   input  bal_pkg::entry_type        prev_entry,
   input  bal_pkg::entry_type        next_entry,
   output bal_pkg::entry_type        entry
);
   import bal_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift_up) begin
         if (index == ctl.ins_pos) begin
            entry_in = ctl.new_entry;
         end else if (index > ctl.ins_pos) begin
            entry_in = prev_entry;
         end
      end else if (ctl.walk) begin
         if (ctl.tail_we && index == ctl.ins_pos) begin
            entry_in = ctl.new_entry;
         end else if (index >= ctl.rem_pos) begin
            entry_in = next_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule

FILE: rtl/bounded_array_list.sv
// Ordered list of up to 128 key/value entries held in a chain of cells.
// One request is served at a time. Append, insert, remove at and read at are
// done in the cycle they are accepted: the row of cells shifts the entries
// behind the position by one place, all in the same cycle, so the result
// is valid in the cycle after accept. Find and delete by key rotate the
// list once through the head cell, one entry per cycle: kept entries go to
// the end of the live list, matches are dropped on delete, so order is
// kept. Their result is valid after the walk state and a finish state; on
// an empty list both states are skipped. The result waits in an output
// register while rsp_valid is high, until rsp_ready is high.
module bounded_array_list (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic signed [31:0] req_item_key,
   input  logic [31:0] req_item_value,
   input  logic [7:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_done_ok,
   output logic signed [31:0] rsp_out_key,
   output logic [31:0] rsp_out_value,
   output logic [7:0]  rsp_removed_count,
   output logic [7:0]  rsp_entry_count_out,
   output logic        rsp_is_empty,
   output logic        rsp_is_full
);
   import bal_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_WALK = 4'b0010,
      ST_RESP = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] step_ff, step_in;
   logic [CntW-1:0] kept_ff, kept_in;
   logic [CntW-1:0] removed_ff, removed_in;
   logic [2:0]  op_ff, op_in;
   logic [31:0] key_ff, key_in;
   logic        ok_ff, ok_in;
   entry_type   found_ff, found_in;
   cell_ctl_type ctl;
   entry_type   cells [Capacity];

   logic [CntW-1:0] pos_ext;
   logic            pos_ok;

   assign pos_ext = CntW'(req_position);
   assign pos_ok  = (req_position != 8'd0) && (pos_ext <= count_ff);

   genvar g;
   generate
      for (g = 0; g < Capacity; g++) begin : g_cell
         entry_type prev_e, next_e;
         if (g == 0) begin : g_first
            assign prev_e = cells[0];
         end else begin : g_mid
            assign prev_e = cells[g-1];
         end
         if (g == Capacity - 1) begin : g_last
            assign next_e = cells[g];
         end else begin : g_mid2
            assign next_e = cells[g+1];
         end
         bal_cell u_cell (
            .clock      (clock),
            .index      (IdxW'(g)),
            .ctl        (ctl),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cells[g])
         );
      end
   endgenerate

   // Walk mode: inspect the head cell each cycle, shift the list down and
   // write a kept head into the last live slot; drop a matching head on delete.
   logic match_head;
   logic [CntW-1:0] live_last;
   assign match_head = (cells[0].key == key_ff);
   assign live_last  = count_ff - removed_ff - 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      step_in    = step_ff;
      kept_in    = kept_ff;
      removed_in = removed_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      ok_in      = ok_ff;
      found_in   = found_ff;
      ctl        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req_type;
               key_in     = req_item_key;
               ok_in      = 1'b0;
               found_in   = '0;
               removed_in = '0;
               kept_in    = '0;
               step_in    = '0;
               state_in   = ST_RESP;
               unique case (req_type) inside
                  OP_APPEND: begin
                     if (count_ff < CntW'(Capacity)) begin
                        ctl.shift_up  = 1'b1;
                        ctl.ins_pos   = count_ff[IdxW-1:0];
                        ctl.new_entry = '{req_item_key, req_item_value};
                        count_in      = count_ff + 1'b1;
                        ok_in         = 1'b1;
                     end
                  end
                  OP_INSERT_AT: begin
                     if (count_ff < CntW'(Capacity) && req_position != 8'd0
                         && pos_ext <= count_ff + 1'b1) begin
                        ctl.shift_up  = 1'b1;
                        ctl.ins_pos   = IdxW'(pos_ext - 1'b1);
                        ctl.new_entry = '{req_item_key, req_item_value};
                        count_in      = count_ff + 1'b1;
                        ok_in         = 1'b1;
                     end
                  end
                  OP_REMOVE_AT: begin
                     if (pos_ok) begin
                        ctl.walk    = 1'b1;
                        ctl.rem_pos = IdxW'(pos_ext - 1'b1);
                        count_in    = count_ff - 1'b1;
                        ok_in       = 1'b1;
                     end
                  end
                  OP_READ_AT: begin
                     if (pos_ok) begin
                        ok_in    = 1'b1;
                        found_in = cells[IdxW'(pos_ext - 1'b1)];
                     end
                  end
                  OP_DELETE_KEY, OP_FIND_KEY: begin
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            // Rotate the live list once; a kept head goes to the last live slot.
            ctl.walk      = 1'b1;
            ctl.rem_pos   = '0;
            ctl.ins_pos   = live_last[IdxW-1:0];
            ctl.new_entry = cells[0];
            ctl.tail_we   = (op_ff == OP_FIND_KEY) || !match_head;
            step_in       = step_ff + 1'b1;
            if (op_ff == OP_FIND_KEY) begin
               if (match_head && !ok_ff) begin
                  ok_in    = 1'b1;
                  found_in = cells[0];
               end
            end else if (match_head) begin
               removed_in = removed_ff + 1'b1;
            end else begin
               kept_in = kept_ff + 1'b1;
            end
            if (step_ff + 1'b1 == count_ff) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (op_ff == OP_DELETE_KEY) begin
               count_in = kept_ff;
               ok_in    = (removed_ff != '0);
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
      end
      step_ff    <= step_in;
      kept_ff    <= kept_in;
      removed_ff <= removed_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      ok_ff      <= ok_in;
      found_ff   <= found_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = (state_ff == ST_RESP);
   assign rsp_done_ok         = ok_ff;
   assign rsp_out_key         = found_ff.key;
   assign rsp_out_value       = found_ff.value;
   assign rsp_removed_count   = 8'(removed_ff);
   assign rsp_entry_count_out = 8'(count_ff);
   assign rsp_is_empty        = (count_ff == '0);
   assign rsp_is_full         = (count_ff == CntW'(Capacity));
endmodule

FILE: tb/sv/bal_list_checker.sv
module bal_list_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic [31:0]       req_item_key,
   input  logic [31:0]       req_item_value,
   input  logic [7:0]        req_position,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              rsp_done_ok,
   input  logic [31:0]       rsp_out_key,
   input  logic [31:0]       rsp_out_value,
   input  logic [7:0]        rsp_removed_count,
   input  logic [7:0]        rsp_entry_count_out,
   input  logic              rsp_is_empty,
   input  logic              rsp_is_full,
   output int                fail_count,
   output int                pending_count,
   output int                list_fill
);
   import bal_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        done_ok;
      logic [31:0] out_key;
      logic [31:0] out_value;
      logic [7:0]  removed;
      logic [7:0]  count;
      logic        empty;
      logic        full;
   } list_answer_type;

   entry_type       shadow_list[$];
   list_answer_type answer_queue[$];

   assign pending_count = answer_queue.size();
   assign list_fill     = shadow_list.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic list_answer_type apply_request(input logic [2:0] op,
         input logic [31:0] key, input logic [31:0] value, input logic [7:0] pos);
      list_answer_type a;
      entry_type e;
      int n;
      a = '0;
      n = shadow_list.size();
      e.key = key;
      e.value = value;
      case (op)
         OP_APPEND: begin
            if (n < Capacity) begin
               shadow_list.push_back(e);
               a.done_ok = 1;
            end
         end
         OP_DELETE_KEY: begin
            for (int i = n - 1; i >= 0; i--)
               if (shadow_list[i].key == key) begin
                  shadow_list.delete(i);
                  a.removed++;
               end
            a.done_ok = a.removed != 0;
         end
         OP_FIND_KEY: begin
            foreach (shadow_list[i])
               if (!a.done_ok && shadow_list[i].key == key) begin
                  a.done_ok = 1;
                  a.out_key = shadow_list[i].key;
                  a.out_value = shadow_list[i].value;
               end
         end
         OP_INSERT_AT: begin
            if (n < Capacity && pos >= 1 && pos <= n + 1) begin
               shadow_list.insert(pos - 1, e);
               a.done_ok = 1;
            end
         end
         OP_REMOVE_AT: begin
            if (pos >= 1 && pos <= n) begin
               shadow_list.delete(pos - 1);
               a.done_ok = 1;
            end
         end
         OP_READ_AT: begin
            if (pos >= 1 && pos <= n) begin
               a.done_ok = 1;
               a.out_key = shadow_list[pos-1].key;
               a.out_value = shadow_list[pos-1].value;
            end
         end
         default: ;
      endcase
      a.count = 8'(shadow_list.size());
      a.empty = shadow_list.size() == 0;
      a.full  = shadow_list.size() == Capacity;
      return a;
   endfunction

   always @(posedge clock) begin
      list_answer_type want;
      if (reset) begin
         fail_count = 0;
         shadow_list.delete();
         answer_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = answer_queue.pop_front();
               if (rsp_done_ok !== want.done_ok)
                  report_mismatch("done_ok", rsp_done_ok, want.done_ok);
               if (rsp_out_key !== want.out_key)
                  report_mismatch("out_key", rsp_out_key, want.out_key);
               if (rsp_out_value !== want.out_value)
                  report_mismatch("out_value", rsp_out_value, want.out_value);
               if (rsp_removed_count !== want.removed)
                  report_mismatch("removed_count", rsp_removed_count, want.removed);
               if (rsp_entry_count_out !== want.count)
                  report_mismatch("entry_count_out", rsp_entry_count_out, want.count);
               if (rsp_is_empty !== want.empty)
                  report_mismatch("is_empty", rsp_is_empty, want.empty);
               if (rsp_is_full !== want.full)
                  report_mismatch("is_full", rsp_is_full, want.full);
            end
         end
         if (req_valid && req_ready)
            answer_queue.push_back(apply_request(req_type, req_item_key,
                                                 req_item_value, req_position));
      end
   end
endmodule

FILE: tb/sv/tb_bounded_array_list.sv
module tb_bounded_array_list;
   import bal_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit = 2000;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [31:0] req_item_key = '0;
   logic [31:0] req_item_value = '0;
   logic [7:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_done_ok;
   logic [31:0] rsp_out_key;
   logic [31:0] rsp_out_value;
   logic [7:0]  rsp_removed_count;
   logic [7:0]  rsp_entry_count_out;
   logic        rsp_is_empty;
   logic        rsp_is_full;
   int          fail_count;
   int          pending_count;
   int          list_fill;
   int          quiet_cycles = 0;
   bit          steady = 0;
   logic [31:0] key_pool[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

   bounded_array_list i_dut (.*);

   bal_list_checker i_checker (.*);

   initial forever #1 clock = ~clock;

   always @(negedge clock)
      if (!reset)
         rsp_ready <= steady || ($urandom_range(99) >= 19);

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_beat(input logic [2:0] op, input logic [31:0] key,
                            input logic [31:0] value, input logic [7:0] pos);
      while (!steady && $urandom_range(99) < 19) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_type <= op;
      req_item_key <= key;
      req_item_value <= value;
      req_position <= pos;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      return ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(3)];
   endfunction

   function automatic logic [7:0] pick_position();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 8'd0;
      if (r == 1) return 8'($urandom_range(255));
      return 8'($urandom_range(list_fill + 1));
   endfunction

   initial begin
      logic [2:0] op;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: empty-list failures, extremes, fill to capacity, then overflow
      send_beat(OP_REMOVE_AT, 0, 0, 1);
      send_beat(OP_READ_AT, 0, 0, 0);
      send_beat(OP_DELETE_KEY, 32'h5, 0, 0);
      send_beat(OP_FIND_KEY, 32'h5, 0, 0);
      send_beat(OP_INSERT_AT, 32'h8000_0000, 32'hffff_ffff, 2);
      send_beat(OP_INSERT_AT, 32'h8000_0000, 32'hffff_ffff, 1);
      send_beat(OP_APPEND, 32'h7fff_ffff, 32'h0, 0);
      send_beat(OP_INSERT_AT, 32'h8000_0000, 32'h1234, 3);
      send_beat(OP_FIND_KEY, 32'h8000_0000, 0, 0);
      send_beat(OP_READ_AT, 0, 0, 3);
      send_beat(OP_READ_AT, 0, 0, 4);
      send_beat(OP_DELETE_KEY, 32'h8000_0000, 0, 0);
      send_beat(OP_SPARE_LO, 0, 0, 0);
      send_beat(OP_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
      send_beat(OP_REMOVE_AT, 0, 0, 1);
      steady = 1;
      while (list_fill < Capacity) send_beat(OP_APPEND, pick_key(), $urandom(), 0);
      steady = 0;
      send_beat(OP_APPEND, 1, 1, 0);
      send_beat(OP_INSERT_AT, 1, 1, 1);
      send_beat(OP_READ_AT, 0, 0, 128);
      send_beat(OP_READ_AT, 0, 0, 129);
      send_beat(OP_DELETE_KEY, key_pool[$urandom_range(3)], 0, 0);
      // random mix, with one stretch of no idling
      for (int n = 0; n < 250; n++) begin
         steady = (n >= 150 && n < 200);
         op = 3'($urandom_range(7));
         if (op > OP_READ_AT && $urandom_range(3) != 0) op = 3'($urandom_range(5));
         if (list_fill < 8 && $urandom_range(1)) op = OP_APPEND;
         send_beat(op, pick_key(), $urandom(), pick_position());
      end
      steady = 0;
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
